### hdl/kmd_pkg.sv
// Package for the keypad matrix debouncer.
// Holds the matrix geometry, register indexes and types shared by all modules.
// No dependencies.
`default_nettype none

package kmd_pkg;

    localparam int ROWS     = 4;
    localparam int COLS     = 3;
    localparam int NKEYS    = ROWS * COLS;
    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;
    localparam int POS_W    = 2;

    localparam logic [CFG_W-1:0] SCAN_INTERVAL_RST = 16'd10;
    localparam logic [CFG_W-1:0] DEBOUNCE_RST      = 16'd20;
    localparam logic [NKEYS-1:0] KEY_ENABLE_RST    = 12'd3071;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCAN_INTERVAL = 2'd0,
        REG_DEBOUNCE      = 2'd1,
        REG_KEY_ENABLE    = 2'd2
    } t_cfg_reg;

    typedef struct packed {
        logic changed;
        logic level;
    } t_lane_res;

endpackage

`default_nettype wire

### hdl/keypad_matrix_debouncer.sv
// Top level of the keypad matrix debouncer: registers, scan gate, twelve lanes and merge.
// Depends on kmd_pkg, kmd_lane and kmd_merge.
//
//  Channel   Signals                                     Direction
//  in        i_in_valid/o_in_ready, raw_pressed, now_ms   word in
//  out       o_out_valid/i_out_ready, row, col, pressed, last  word out
//  cfg       i_cfg_we, i_cfg_idx, i_cfg_data              write only
//
// Enabled keys are updated in the cycle a word is accepted after the scan interval elapses;
// a scan then emits one changed key per cycle while the output is not stalled. A scan with
// changed keys holds the input until they drain; a scan with no changes does not hold it.
// A new word is taken as soon as the previous scan's changes are all in the output register.
// Reset is synchronous and active low and restores the register defaults.
// A stalled output holds the pending changes and blocks new words until they drain.
`default_nettype none

module keypad_matrix_debouncer
    import kmd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [NKEYS-1:0]     i_raw_pressed,
    input  wire logic [TIME_W-1:0]    i_now_ms,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [POS_W-1:0]          o_key_row,
    output logic [POS_W-1:0]          o_key_col,
    output logic                      o_pressed,
    output logic                      o_last,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0]  r_scan_interval;
    logic [CFG_W-1:0]  r_debounce;
    logic [NKEYS-1:0]  r_key_enable;
    logic [TIME_W-1:0] r_last_scan;
    logic              accept;
    logic              scan_due;
    logic              update;
    t_lane_res         lane_res [NKEYS];

    assign accept   = i_in_valid && o_in_ready;
    assign scan_due = (i_now_ms - r_last_scan) >= TIME_W'(r_scan_interval);
    assign update   = accept && scan_due;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_interval <= SCAN_INTERVAL_RST;
            r_debounce      <= DEBOUNCE_RST;
            r_key_enable    <= KEY_ENABLE_RST;
            r_last_scan     <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SCAN_INTERVAL: r_scan_interval <= i_cfg_data;
                    REG_DEBOUNCE:      r_debounce      <= i_cfg_data;
                    REG_KEY_ENABLE:    r_key_enable    <= i_cfg_data[NKEYS-1:0];
                    default:           ;
                endcase
            end
            if (update) begin
                r_last_scan <= i_now_ms;
            end
        end
    end

    for (genvar k = 0; k < NKEYS; k++) begin : g_lane
        kmd_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_update   (update),
            .i_enable   (r_key_enable[k]),
            .i_raw      (i_raw_pressed[k]),
            .i_now      (i_now_ms),
            .i_debounce (r_debounce),
            .o_res      (lane_res[k])
        );
    end

    kmd_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (update),
        .i_res       (lane_res),
        .o_ready     (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_key_row   (o_key_row),
        .o_key_col   (o_key_col),
        .o_pressed   (o_pressed),
        .o_last      (o_last)
    );

endmodule

`default_nettype wire

### hdl/kmd_lane.sv
// One debounce lane: candidate level, its start time and the debounced level of one key.
// Depends on kmd_pkg.
`default_nettype none

module kmd_lane
    import kmd_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_update,
    input  wire logic              i_enable,
    input  wire logic              i_raw,
    input  wire logic [TIME_W-1:0] i_now,
    input  wire logic [CFG_W-1:0]  i_debounce,
    output t_lane_res              o_res
);

    logic              r_cand;
    logic              r_deb;
    logic [TIME_W-1:0] r_since;
    logic              n_cand;
    logic              n_deb;
    logic [TIME_W-1:0] n_since;
    logic [TIME_W-1:0] held;
    logic              settle;

    assign held   = i_now - r_since;
    assign settle = (r_deb != r_cand) && (held >= TIME_W'(i_debounce));

    always_comb begin
        n_cand        = r_cand;
        n_deb         = r_deb;
        n_since       = r_since;
        o_res.changed = 1'b0;
        o_res.level   = r_cand;
        if (i_update && i_enable) begin
            if (i_raw != r_cand) begin
                n_cand  = i_raw;
                n_since = i_now;
            end else if (settle) begin
                n_deb         = r_cand;
                o_res.changed = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand  <= 1'b0;
            r_deb   <= 1'b0;
            r_since <= '0;
        end else begin
            r_cand  <= n_cand;
            r_deb   <= n_deb;
            r_since <= n_since;
        end
    end

endmodule

`default_nettype wire

### hdl/kmd_merge.sv
// Merging stage: collects the change flags of all lanes and emits them in row-major order.
// Depends on kmd_pkg.
`default_nettype none

module kmd_merge
    import kmd_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_load,
    input  wire t_lane_res        i_res [NKEYS],
    output logic                  o_ready,
    output logic                  o_out_valid,
    input  wire logic             i_out_ready,
    output logic [POS_W-1:0]      o_key_row,
    output logic [POS_W-1:0]      o_key_col,
    output logic                  o_pressed,
    output logic                  o_last
);

    logic [NKEYS-1:0] r_mask;
    logic [NKEYS-1:0] r_lvl;
    logic [NKEYS-1:0] n_mask;
    logic [NKEYS-1:0] n_lvl;
    logic [NKEYS-1:0] pop_bit;
    logic [NKEYS-1:0] rest;
    logic [POS_W-1:0] sel_row;
    logic [POS_W-1:0] sel_col;
    logic             out_free;
    logic             pop;
    logic             r_out_valid;
    logic [POS_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic             r_pressed;
    logic             r_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign pop      = out_free && (r_mask != '0);
    assign pop_bit  = r_mask & (~r_mask + NKEYS'(1));
    assign rest     = pop ? (r_mask & ~pop_bit) : r_mask;
    assign o_ready  = (rest == '0);

    always_comb begin
        sel_row = '0;
        sel_col = '0;
        for (int r = ROWS - 1; r >= 0; r--) begin
            for (int c = COLS - 1; c >= 0; c--) begin
                if (r_mask[r * COLS + c]) begin
                    sel_row = POS_W'(r);
                    sel_col = POS_W'(c);
                end
            end
        end
    end

    always_comb begin
        n_mask = rest;
        n_lvl  = r_lvl;
        if (i_load) begin
            for (int k = 0; k < NKEYS; k++) begin
                n_mask[k] = i_res[k].changed;
                n_lvl[k]  = i_res[k].level;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_mask <= n_mask;
            if (out_free) begin
                r_out_valid <= pop;
            end
        end
        r_lvl <= n_lvl;
        if (pop) begin
            r_row     <= sel_row;
            r_col     <= sel_col;
            r_pressed <= |(r_lvl & pop_bit);
            r_last    <= ((r_mask & ~pop_bit) == '0);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_key_row   = r_row;
    assign o_key_col   = r_col;
    assign o_pressed   = r_pressed;
    assign o_last      = r_last;

    a_load_only_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (rest == '0))
        else $error("scan loaded while earlier changes were still pending");

    a_pop_single_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(pop_bit))
        else $error("more than one key selected for output");

    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_col < POS_W'(COLS)))
        else $error("column out of range on output");

    a_pending_pops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mask != '0) && out_free |=> r_out_valid)
        else $error("pending change was not moved to the output register");

endmodule

`default_nettype wire
